@@ src/vpa_pkg.sv @@
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared types and codes for the variable partition allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_NOJOB = 2'd3;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TERM = 1'b1;

    localparam logic CFG_FIT_POLICY  = 1'b0;
    localparam logic CFG_MEMORY_SIZE = 1'b1;

    localparam logic [15:0] MEM_SIZE_RESET = 16'd1024;

    // command from the sequencer to the segment table
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } tbl_ctl_t;

endpackage

@@ src/variable_partition_allocator.sv @@
// ----------------------------------------------------------------------------
// variable_partition_allocator
// Dynamic partition allocator with first fit / best fit search.
// ----------------------------------------------------------------------------
// Usage: a request transaction (req_type, job_id, request_size) enters on
// in_valid/in_stall; one result transaction (success, segment_address,
// status_code) leaves on out_valid/out_stall for every request.
// The segment table lives in one synchronous RAM of 2**AW entries, enough for
// MAX_SEGMENTS, with one read and one write port, so requests are handled one
// at a time. A request first scans the table; a load without a split then
// finishes. A split moves entries pick+1..count-1 up by one (count-1-pick
// entries) and then writes both halves. A terminate compacts the table after
// its scan; an unknown job ends after the scan. The block returns to idle and
// takes a new request once the previous result is loaded into the output
// register.
// The result holds in that register while out_stall is high; the next request
// may run meanwhile and waits in its last state until the register frees up.
// Reset (and a memory_size write) rewrites entry 0 as one free segment and
// sets the count to one. in_stall is high during a configuration
// write; writes are expected only while the block is idle.
// ----------------------------------------------------------------------------
module variable_partition_allocator #(
    parameter int MAX_SEGMENTS = 16,
    parameter int SIZE_BITS    = 16,
    parameter int JOB_ID_BITS  = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    req_type,
    input  logic [JOB_ID_BITS-1:0]  job_id,
    input  logic [SIZE_BITS-1:0]    request_size,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    success,
    output logic [15:0]             segment_address,
    output logic [1:0]              status_code,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [15:0]             cfg_data
);
    import vpa_pkg::*;

    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int DW = 2 * SIZE_BITS + 1 + JOB_ID_BITS;

    typedef struct packed {
        logic [SIZE_BITS-1:0]   start;
        logic [SIZE_BITS-1:0]   len;
        logic                   busy;
        logic [JOB_ID_BITS-1:0] owner;
    } seg_t;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SCAN, S_DECIDE, S_SHIFT_RD, S_SHIFT_WR, S_SPLIT,
        S_REMAIN, S_MERGE, S_MERGE_FLUSH, S_DONE
    } state_t;

    state_t               state_reg;
    logic                 fit_reg;
    logic [15:0]          msize_reg;
    logic [CW-1:0]        count_reg;
    logic                 req_reg;
    logic [JOB_ID_BITS-1:0] job_reg;
    logic [SIZE_BITS-1:0] size_reg;
    logic [CW-1:0]        rd_idx_reg;   // next address to read
    logic [CW-1:0]        chk_idx_reg;  // address of rd_data
    logic                 chk_vld_reg;
    logic                 found_reg;
    logic [AW-1:0]        pick_reg;
    seg_t                 pick_seg_reg;
    seg_t                 acc_reg;      // merge accumulator
    logic                 acc_vld_reg;
    logic [CW-1:0]        wr_idx_reg;   // merge write pointer
    logic                 out_valid_reg;
    logic                 success_reg;
    logic [15:0]          addr_reg;
    logic [1:0]           status_reg;
    logic                 out_ok_reg;
    logic [15:0]          out_addr_reg;
    logic [1:0]           out_status_reg;

    tbl_ctl_t             ctl;
    logic [AW-1:0]        wr_addr;
    seg_t                 wr_seg;
    logic [AW-1:0]        rd_addr;
    logic [DW-1:0]        rd_raw;
    seg_t                 rd_seg;

    vpa_seg_table #(.AW(AW), .DW(DW)) u_table (
        .clk     (clk),
        .ctl     (ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_seg),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign rd_seg = seg_t'(rd_raw);

    logic in_acc;
    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE) || cfg_we;
    assign out_valid       = out_valid_reg;
    assign success         = out_ok_reg;
    assign segment_address = out_addr_reg;
    assign status_code     = out_status_reg;

    logic scan_hit;
    logic chk_last;
    assign scan_hit = chk_vld_reg && !rd_seg.busy && (rd_seg.len >= size_reg)
                      && (size_reg != '0);
    assign chk_last = (chk_idx_reg == count_reg - CW'(1));

    // table port control
    always_comb
    begin
        ctl     = '{wr_en: 1'b0, rd_en: 1'b0};
        wr_addr = '0;
        wr_seg  = '0;
        rd_addr = rd_idx_reg[AW-1:0];
        case (state_reg)
            S_INIT:
            begin
                ctl.wr_en = 1'b1;
                wr_seg    = '{start: '0, len: SIZE_BITS'(msize_reg), busy: 1'b0,
                              owner: '0};
            end
            S_SCAN, S_MERGE:
            begin
                ctl.rd_en = (rd_idx_reg < count_reg);
                if (state_reg == S_MERGE && chk_vld_reg && acc_vld_reg &&
                    !(!rd_seg.busy && !acc_reg.busy))
                begin
                    ctl.wr_en = 1'b1;
                    wr_addr   = wr_idx_reg[AW-1:0];
                    wr_seg    = acc_reg;
                end
            end
            S_SHIFT_RD:
            begin
                ctl.rd_en = 1'b1;
            end
            S_SHIFT_WR:
            begin
                ctl.wr_en = 1'b1;
                wr_addr   = rd_idx_reg[AW-1:0] + AW'(1);
                wr_seg    = rd_seg;
            end
            S_SPLIT:
            begin
                ctl.wr_en = 1'b1;
                wr_addr   = pick_reg;
                wr_seg    = '{start: pick_seg_reg.start, len: size_reg, busy: 1'b1,
                              owner: job_reg};
            end
            S_REMAIN:
            begin
                // free remainder of a split
                ctl.wr_en = 1'b1;
                wr_addr   = pick_reg + AW'(1);
                wr_seg    = '{start: pick_seg_reg.start + size_reg,
                              len: pick_seg_reg.len - size_reg,
                              busy: 1'b0, owner: '0};
            end
            S_DECIDE:
            begin
                // exact fit: mark the picked entry busy in place
                if (found_reg && pick_seg_reg.len == size_reg)
                begin
                    ctl.wr_en = 1'b1;
                    wr_addr   = pick_reg;
                    wr_seg    = '{start: pick_seg_reg.start, len: size_reg, busy: 1'b1,
                                  owner: job_reg};
                end
            end
            S_MERGE_FLUSH:
            begin
                ctl.wr_en = 1'b1;
                wr_addr   = wr_idx_reg[AW-1:0];
                wr_seg    = acc_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            fit_reg       <= 1'b0;
            msize_reg     <= MEM_SIZE_RESET;
            count_reg     <= CW'(1);
            out_valid_reg <= 1'b0;
            chk_vld_reg   <= 1'b0;
            rd_idx_reg    <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_FIT_POLICY)
                begin
                    fit_reg <= cfg_data[0];
                end
                else
                begin
                    msize_reg <= cfg_data;
                    state_reg <= S_INIT;
                end
            end
            case (state_reg)
                S_INIT:
                begin
                    count_reg <= CW'(1);
                    if (!(cfg_we && cfg_index == CFG_MEMORY_SIZE))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_acc && !cfg_we)
                    begin
                        req_reg     <= req_type;
                        job_reg     <= job_id;
                        size_reg    <= request_size;
                        rd_idx_reg  <= '0;
                        chk_vld_reg <= 1'b0;
                        found_reg   <= 1'b0;
                        state_reg   <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    chk_vld_reg <= (rd_idx_reg < count_reg);
                    chk_idx_reg <= rd_idx_reg;
                    rd_idx_reg  <= rd_idx_reg + CW'(1);
                    if (chk_vld_reg)
                    begin
                        if (req_reg == REQ_TERM)
                        begin
                            if (rd_seg.busy && rd_seg.owner == job_reg)
                            begin
                                // free it, then compact from entry 0
                                addr_reg      <= 16'(rd_seg.start);
                                pick_reg      <= chk_idx_reg[AW-1:0];
                                found_reg     <= 1'b1;
                                rd_idx_reg    <= '0;
                                chk_vld_reg   <= 1'b0;
                                acc_vld_reg   <= 1'b0;
                                wr_idx_reg    <= '0;
                                state_reg     <= S_MERGE;
                            end
                            else if (chk_last)
                            begin
                                success_reg   <= 1'b0;
                                addr_reg      <= '0;
                                status_reg    <= ST_NOJOB;
                                state_reg     <= S_DONE;
                            end
                        end
                        else
                        begin
                            if (scan_hit && (!found_reg ||
                                (fit_reg && rd_seg.len < pick_seg_reg.len)))
                            begin
                                found_reg    <= 1'b1;
                                pick_reg     <= chk_idx_reg[AW-1:0];
                                pick_seg_reg <= rd_seg;
                            end
                            if (chk_last || (scan_hit && !fit_reg))
                            begin
                                state_reg <= S_DECIDE;
                            end
                        end
                    end
                end
                S_DECIDE:
                begin
                    if (!found_reg)
                    begin
                        success_reg <= 1'b0;
                        addr_reg    <= '0;
                        status_reg  <= ST_NOFIT;
                        state_reg   <= S_DONE;
                    end
                    else if (pick_seg_reg.len == size_reg)
                    begin
                        success_reg <= 1'b1;
                        addr_reg    <= 16'(pick_seg_reg.start);
                        status_reg  <= ST_OK;
                        state_reg   <= S_DONE;
                    end
                    else if (count_reg >= CW'(MAX_SEGMENTS))
                    begin
                        success_reg <= 1'b0;
                        addr_reg    <= '0;
                        status_reg  <= ST_FULL;
                        state_reg   <= S_DONE;
                    end
                    else
                    begin
                        // move entries pick+1.. up by one, top entry first
                        rd_idx_reg <= count_reg - CW'(1);
                        state_reg  <= (count_reg - CW'(1) > CW'(pick_reg))
                                      ? S_SHIFT_RD : S_SPLIT;
                    end
                end
                S_SHIFT_RD:
                begin
                    state_reg <= S_SHIFT_WR;
                end
                S_SHIFT_WR:
                begin
                    if (rd_idx_reg - CW'(1) > CW'(pick_reg))
                    begin
                        rd_idx_reg <= rd_idx_reg - CW'(1);
                        state_reg  <= S_SHIFT_RD;
                    end
                    else
                    begin
                        state_reg <= S_SPLIT;
                    end
                end
                S_SPLIT:
                begin
                    count_reg   <= count_reg + CW'(1);
                    success_reg <= 1'b1;
                    addr_reg    <= 16'(pick_seg_reg.start);
                    status_reg  <= ST_OK;
                    state_reg   <= S_REMAIN;
                end
                S_REMAIN:
                begin
                    state_reg <= S_DONE;
                end
                S_MERGE:
                begin
                    chk_vld_reg <= (rd_idx_reg < count_reg);
                    chk_idx_reg <= rd_idx_reg;
                    rd_idx_reg  <= rd_idx_reg + CW'(1);
                    if (chk_vld_reg)
                    begin
                        seg_t cur;
                        cur = rd_seg;
                        if (chk_idx_reg[AW-1:0] == pick_reg)
                        begin
                            cur.busy  = 1'b0;
                            cur.owner = '0;
                        end
                        if (acc_vld_reg && !cur.busy && !acc_reg.busy)
                        begin
                            acc_reg.len <= acc_reg.len + cur.len;
                        end
                        else
                        begin
                            if (acc_vld_reg)
                            begin
                                wr_idx_reg <= wr_idx_reg + CW'(1);
                            end
                            acc_reg <= cur;
                        end
                        acc_vld_reg <= 1'b1;
                        if (chk_last)
                        begin
                            state_reg <= S_MERGE_FLUSH;
                        end
                    end
                end
                S_MERGE_FLUSH:
                begin
                    count_reg   <= wr_idx_reg + CW'(1);
                    success_reg <= 1'b1;
                    status_reg  <= ST_OK;
                    state_reg   <= S_DONE;
                end
                S_DONE:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_ok_reg     <= success_reg;
                        out_addr_reg   <= addr_reg;
                        out_status_reg <= status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> out_valid)
        else $error("result not presented after request finished");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CW'(1)) && (count_reg <= CW'(MAX_SEGMENTS)))
        else $error("segment count out of range");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("request taken while busy");
`endif

endmodule

@@ src/vpa_seg_table.sv @@
// ----------------------------------------------------------------------------
// vpa_seg_table
// Segment table memory: one synchronous write port, one synchronous read port.
// ----------------------------------------------------------------------------
module vpa_seg_table #(
    parameter int AW = 4,
    parameter int DW = 41
) (
    input  logic                    clk,
    input  vpa_pkg::tbl_ctl_t       ctl,
    input  logic [AW-1:0]           wr_addr,
    input  logic [DW-1:0]           wr_data,
    input  logic [AW-1:0]           rd_addr,
    output logic [DW-1:0]           rd_data
);
    import vpa_pkg::*;

    logic [DW-1:0] mem [0:(1<<AW)-1];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
